FILE: hdl/fst_pkg.sv
// ============================================================================
// fst_pkg: shared types and constants of the flow statistics table
// Beat types of both channels, event codes, job type between the front and
// back parts, and the saturating counter helper.
// ============================================================================
`default_nettype none

package fst_pkg;

  localparam int FLOW_SLOTS_DEF = 256;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam int ID_W   = 8;
  localparam int CODE_W = 3;
  localparam int EVT_W  = 32;
  localparam int CTR_W  = 32;
  localparam int NUM_W  = 9;

  localparam logic [CODE_W-1:0] CODE_SEND = 3'd0;
  localparam logic [CODE_W-1:0] CODE_RECV = 3'd3;
  localparam logic [CODE_W-1:0] CODE_DROP = 3'd4;

  localparam logic [NUM_W-1:0] NUM_MAX = '1;
  localparam logic [CTR_W-1:0] CTR_MAX = '1;

  typedef enum logic [2:0] {
    OP_LEARN,
    OP_SEND,
    OP_RECV,
    OP_DROP,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [ID_W-1:0]   flow_id;
    logic [CODE_W-1:0] event_code;
    logic [EVT_W-1:0]  event_time;
  } flow_event_t;

  typedef struct packed {
    logic             flow_found;
    logic             flow_created;
    logic [CTR_W-1:0] sent_total;
    logic [CTR_W-1:0] received_total;
    logic [CTR_W-1:0] lost_total;
    logic [NUM_W-1:0] active_flow_count;
    logic [NUM_W-1:0] known_flow_count;
  } flow_result_t;

  // One classified event as it waits in the queue between front and back.
  typedef struct packed {
    logic             in_range;
    op_t              op;
    logic [ID_W-1:0]  flow_id;
    logic [EVT_W-1:0] event_time;
  } job_t;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    sat_inc = (v == CTR_MAX) ? v : v + CTR_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/flow_statistics_table_top.sv
// ============================================================================
// flow_statistics_table_top: per-flow statistics table for trace events
// Learns flows and their first and last event times, then counts sent,
// received and lost packets per flow and tracks the number of active flows.
// ============================================================================
// Usage:
// Event beats (flow id, event code, event time) enter on the in_ channel and
// each produces exactly one result beat on the out_ channel, in order. The
// cfg_ port writes the pass mode (0 learn, 1 count); write it only while no
// beat is in flight. Each channel is valid/ready: a beat moves on a clock
// edge where both are high.
// A beat passes the queue slot, the update stage and the result register.
// Throughput is one beat per cycle while out_ready stays high, including
// back-to-back beats on the same flow, because the entry written by one
// beat is forwarded into the read-modify-write of the next; the single
// write port of the entry memory sets that rate of one update per cycle.
// After reset the valid marks of all FLOW_SLOTS entries are cleared one entry
// per cycle, and in_ready stays low until all are cleared; configuration
// writes are taken meanwhile. When the receiver stalls, the result register
// and the update stage hold, the two-beat queue fills and in_ready then drops;
// no beat is lost or repeated.
// ============================================================================
`default_nettype none

module flow_statistics_table_top #(
  parameter int FLOW_SLOTS = fst_pkg::FLOW_SLOTS_DEF,
  parameter int TIME_WIDTH = fst_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire fst_pkg::flow_event_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output fst_pkg::flow_result_t      out_data
);

  import fst_pkg::*;

  // Front to queue.
  logic q_push;
  job_t q_push_data;
  logic q_full;

  // Queue to back.
  logic q_pop;
  job_t q_pop_data;
  logic q_not_empty;

  // High while the valid marks are being cleared after reset.
  logic clr_busy;

  fst_front #(
    .FLOW_SLOTS (FLOW_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .clr_busy  (clr_busy),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  fst_queue #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  // The table update engine; it also runs the clearing pass after reset.
  fst_back #(
    .FLOW_SLOTS (FLOW_SLOTS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .clr_busy  (clr_busy)
  );

endmodule

`default_nettype wire

FILE: hdl/fst_ram.sv
// ============================================================================
// fst_ram: generic simple dual-port RAM
// One write port and one read port with registered read data; a read of the
// address being written returns the old contents.
// ============================================================================
`default_nettype none

module fst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/fst_queue.sv
// ============================================================================
// fst_queue: short job queue
// Small first-in first-out buffer that decouples the front from the back.
// ============================================================================
`default_nettype none

module fst_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rptr_r];

endmodule

`default_nettype wire

FILE: hdl/fst_front.sv
// ============================================================================
// fst_front: event intake and classification
// Holds the pass mode register, accepts event beats and turns each into a
// job with its operation and table range check.
// ============================================================================
`default_nettype none

module fst_front #(
  parameter int FLOW_SLOTS = fst_pkg::FLOW_SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fst_pkg::flow_event_t in_data,
  input  wire logic                q_full,
  input  wire logic                clr_busy,
  output logic                     q_push,
  output fst_pkg::job_t            q_data
);

  import fst_pkg::*;

  logic        pass_mode_r;
  logic [31:0] id_ext;
  op_t         op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_mode_r <= 1'b0;
    end else if (cfg_we) begin
      pass_mode_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (!pass_mode_r) begin
      op = OP_LEARN;
    end else begin
      case (in_data.event_code)
        CODE_SEND: op = OP_SEND;
        CODE_RECV: op = OP_RECV;
        CODE_DROP: op = OP_DROP;
        default:   op = OP_NONE;
      endcase
    end
  end

  assign id_ext = {{(32 - ID_W){1'b0}}, in_data.flow_id};

  assign in_ready          = !q_full && !clr_busy;
  assign q_push            = in_valid && in_ready;
  assign q_data.in_range   = (id_ext < 32'(FLOW_SLOTS));
  assign q_data.op         = op;
  assign q_data.flow_id    = in_data.flow_id;
  assign q_data.event_time = in_data.event_time;

endmodule

`default_nettype wire

FILE: hdl/fst_back.sv
// ============================================================================
// fst_back: table update engine
// Reads the flow entry, applies the job with forwarding from the previous
// write, writes the entry back and registers the result beat.
// ============================================================================
`default_nettype none

module fst_back #(
  parameter int FLOW_SLOTS = fst_pkg::FLOW_SLOTS_DEF,
  parameter int TIME_WIDTH = fst_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  input  wire fst_pkg::job_t        q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output fst_pkg::flow_result_t     out_data,
  output logic                      clr_busy
);

  import fst_pkg::*;

  localparam int IDX_W = $clog2(FLOW_SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FLOW_SLOTS - 1);

  typedef struct packed {
    logic [TIME_WIDTH-1:0] first_seen;
    logic [TIME_WIDTH-1:0] last_seen;
    logic [CTR_W-1:0]      sent;
    logic [CTR_W-1:0]      received;
    logic [CTR_W-1:0]      lost;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Clearing pass of the valid marks after reset.
  logic             clr_busy_r, clr_busy_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Update stage and result register.
  logic         b_valid_r;
  job_t         b_job_r;
  logic         b_hit_r;
  entry_t       fwd_entry_r;
  logic         fwd_vld_r;
  logic         out_valid_r;
  flow_result_t out_r;
  logic [NUM_W-1:0] known_r, known_nxt;
  logic [NUM_W-1:0] active_r, active_nxt;

  logic             out_free;
  logic             b_fire;
  logic             issue;
  logic [15:0]      q_id_ext;
  logic [15:0]      b_id_ext;
  logic [IDX_W-1:0] q_idx;
  logic [IDX_W-1:0] b_idx;
  logic [63:0]      t_ext;
  logic [TIME_WIDTH-1:0] t;

  logic [ENTRY_W-1:0] ram_rdata;
  logic               vram_rdata;
  entry_t             cur;
  logic               cur_vld;
  entry_t             upd;
  logic               upd_vld;
  logic               found;
  logic               created;
  logic               wr_en;
  logic               vwe;
  logic [IDX_W-1:0]   vwaddr;
  logic               vwdata;
  flow_result_t       res;

  assign q_id_ext = {{(16 - ID_W){1'b0}}, q_data.flow_id};
  assign b_id_ext = {{(16 - ID_W){1'b0}}, b_job_r.flow_id};
  assign q_idx    = q_id_ext[IDX_W-1:0];
  assign b_idx    = b_id_ext[IDX_W-1:0];
  assign t_ext    = {{(64 - EVT_W){1'b0}}, b_job_r.event_time};
  assign t        = t_ext[TIME_WIDTH-1:0];

  assign out_free = !out_valid_r || out_ready;
  assign b_fire   = b_valid_r && out_free;
  assign issue    = q_valid && !clr_busy_r && (!b_valid_r || b_fire);
  assign q_pop    = issue;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      if (clr_cnt_r == IDX_LAST) begin
        clr_busy_nxt = 1'b0;
      end else begin
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
      end
    end
  end

  always_comb begin
    cur        = b_hit_r ? fwd_entry_r : entry_t'(ram_rdata);
    cur_vld    = b_hit_r ? fwd_vld_r : vram_rdata;
    found      = b_job_r.in_range && cur_vld;
    upd        = cur;
    upd_vld    = cur_vld;
    created    = 1'b0;
    known_nxt  = known_r;
    active_nxt = active_r;
    if (b_job_r.in_range) begin
      case (b_job_r.op)
        OP_LEARN: begin
          if (found) begin
            upd.last_seen = t;
          end else begin
            upd.first_seen = t;
            upd.last_seen  = t;
            upd.sent       = '0;
            upd.received   = '0;
            upd.lost       = '0;
            upd_vld        = 1'b1;
            created        = 1'b1;
            if (known_r != NUM_MAX) begin
              known_nxt = known_r + NUM_W'(1);
            end
          end
        end
        OP_SEND: begin
          if (found) begin
            upd.sent = sat_inc(cur.sent);
            if (t == cur.first_seen && active_r != NUM_MAX) begin
              active_nxt = active_r + NUM_W'(1);
            end
          end
        end
        OP_RECV, OP_DROP: begin
          if (found) begin
            if (t == cur.last_seen && active_r != '0) begin
              active_nxt = active_r - NUM_W'(1);
            end
            if (b_job_r.op == OP_RECV) begin
              upd.received = sat_inc(cur.received);
            end else begin
              upd.lost = sat_inc(cur.lost);
            end
          end
        end
        default: begin
        end
      endcase
    end

    res.flow_found        = found;
    res.flow_created      = created;
    res.sent_total        = '0;
    res.received_total    = '0;
    res.lost_total        = '0;
    res.active_flow_count = active_nxt;
    res.known_flow_count  = known_nxt;
    if (b_job_r.in_range && upd_vld) begin
      res.sent_total     = upd.sent;
      res.received_total = upd.received;
      res.lost_total     = upd.lost;
    end
  end

  assign wr_en  = b_fire && b_job_r.in_range;
  assign vwe    = clr_busy_r || wr_en;
  assign vwaddr = clr_busy_r ? clr_cnt_r : b_idx;
  assign vwdata = clr_busy_r ? 1'b0 : upd_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      b_valid_r   <= 1'b0;
      b_hit_r     <= 1'b0;
      out_valid_r <= 1'b0;
      known_r     <= '0;
      active_r    <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      if (issue) begin
        b_valid_r <= 1'b1;
        // The entry read now misses the write of this edge; forward it.
        b_hit_r   <= b_fire && b_job_r.in_range && q_data.in_range && (b_idx == q_idx);
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
      if (b_fire) begin
        out_valid_r <= 1'b1;
        known_r     <= known_nxt;
        active_r    <= active_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_job_r <= q_data;
    end
    if (b_fire) begin
      fwd_entry_r <= upd;
      fwd_vld_r   <= upd_vld;
      out_r       <= res;
    end
  end

  fst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FLOW_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (b_idx),
    .wdata (upd),
    .re    (issue),
    .raddr (q_idx),
    .rdata (ram_rdata)
  );

  fst_ram #(
    .WIDTH (1),
    .DEPTH (FLOW_SLOTS)
  ) u_valid_ram (
    .clk   (clk),
    .we    (vwe),
    .waddr (vwaddr),
    .wdata (vwdata),
    .re    (issue),
    .raddr (q_idx),
    .rdata (vram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign clr_busy  = clr_busy_r;

endmodule

`default_nettype wire
